// ----- rtl/sprite_frame_sequencer_assert.svh -----
// assertion macros for the sprite frame sequencer
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprite_frame_sequencer: check failed");
// next-cycle implication, checked out of reset
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprite_frame_sequencer: check failed");
`else
`define SFS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/sfs_pkg.sv -----
package sfs_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int TIME_BITS  = 16;

    localparam int FRAME_W = 4;    // frame and table entry index
    localparam int COUNT_W = 5;    // frame_count, timed_entries
    localparam int TICKS_W = 16;   // duration values
    localparam int COORD_W = 12;   // sheet coordinates and frame step
    localparam int RECT_W  = 16;   // saturated rect_x
    localparam int CMD_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICKS_W-1:0] RESET_FRAME_TICKS = 16'd100;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [COUNT_W-1:0] FRAMES_LIMIT = COUNT_W'(MAX_FRAMES);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_PLAY    = 3'd1,
        CMD_PAUSE   = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_RESTART = 3'd4,
        CMD_SHOW    = 3'd5,
        CMD_HIDE    = 3'd6,
        CMD_WRITE   = 3'd7
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_TICKS = 3'd0,
        CFG_LOOP_ENABLE   = 3'd1,
        CFG_FRAME_COUNT   = 3'd2,
        CFG_TIMED_ENTRIES = 3'd3,
        CFG_FRAME_WIDTH   = 3'd4,
        CFG_START_X       = 3'd5,
        CFG_START_Y       = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_index;
        logic [RECT_W-1:0]  rect_x;
        logic [COORD_W-1:0] rect_y;
        logic               is_playing;
        logic               is_finished;
        logic               is_visible;
        logic               advanced;
        logic               rejected;
    } t_result;

endpackage

// ----- rtl/sprite_frame_sequencer.sv -----
// channel   | direction | handshake                   | payload
// ----------+-----------+-----------------------------+------------------------------------
// command   | in        | i_in_valid / o_in_stall     | i_cmd, i_entry_index, i_entry_ticks
// result    | out       | o_out_valid / i_out_stall   | o_frame_index .. o_rejected
// config    | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one item per cycle while o_in_stall is low; its result is registered in the output register on acceptance
// the duration table is read ahead at the next frame into a register, with write forwarding
// o_in_stall is high only while a held result is stalled by i_out_stall
// synchronous active-low reset clears flags, counters, configuration registers (default ticks to 100) and output valid;
// the duration table, its read register and the output data register are not cleared
`include "sprite_frame_sequencer_assert.svh"

module sprite_frame_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [sfs_pkg::CMD_W-1:0]       i_cmd,
    input  logic [sfs_pkg::FRAME_W-1:0]     i_entry_index,
    input  logic [sfs_pkg::TICKS_W-1:0]     i_entry_ticks,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [sfs_pkg::FRAME_W-1:0]     o_frame_index,
    output logic [sfs_pkg::RECT_W-1:0]      o_rect_x,
    output logic [sfs_pkg::COORD_W-1:0]     o_rect_y,
    output logic                            o_is_playing,
    output logic                            o_is_finished,
    output logic                            o_is_visible,
    output logic                            o_advanced,
    output logic                            o_rejected,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CMP_W = (sfs_pkg::TIME_BITS > sfs_pkg::TICKS_W) ?
                           sfs_pkg::TIME_BITS : sfs_pkg::TICKS_W;
    localparam int PROD_W = sfs_pkg::FRAME_W + sfs_pkg::COORD_W;
    localparam int SUM_W  = PROD_W + 1;

    // configuration registers
    logic [sfs_pkg::TICKS_W-1:0] r_default_ticks, n_default_ticks;
    logic                        r_loop_enable, n_loop_enable;
    logic [sfs_pkg::COUNT_W-1:0] r_frame_count, n_frame_count;
    logic [sfs_pkg::COUNT_W-1:0] r_timed_entries, n_timed_entries;
    logic [sfs_pkg::COORD_W-1:0] r_frame_width, n_frame_width;
    logic [sfs_pkg::COORD_W-1:0] r_start_x, n_start_x;
    logic [sfs_pkg::COORD_W-1:0] r_start_y, n_start_y;

    // sequencer state
    logic                          r_playing, n_playing;
    logic                          r_finished, n_finished;
    logic                          r_hidden, n_hidden;
    logic [sfs_pkg::FRAME_W-1:0]   r_frame, n_frame;
    logic [sfs_pkg::TIME_BITS-1:0] r_elapsed, n_elapsed;

    // duration table and its registered read port
    logic [sfs_pkg::TICKS_W-1:0] r_dur_mem [sfs_pkg::MAX_FRAMES];
    logic [sfs_pkg::TICKS_W-1:0] r_dur_q;

    sfs_pkg::t_result r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic                          in_accept;
    logic                          cfg_write;
    logic                          tbl_write;
    sfs_pkg::t_cmd                 cmd;
    logic [sfs_pkg::COUNT_W-1:0]   frames;
    logic [sfs_pkg::COUNT_W-1:0]   timed_lim;
    logic [sfs_pkg::TICKS_W-1:0]   cur_dur;
    logic [sfs_pkg::TIME_BITS-1:0] elapsed_inc;
    logic                          due;
    logic [sfs_pkg::COUNT_W-1:0]   step_frame;
    logic                          advanced;
    logic                          rejected;
    logic [PROD_W-1:0]             rect_prod;
    logic [SUM_W-1:0]              rect_sum;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;
    assign cmd         = sfs_pkg::t_cmd'(i_cmd);
    assign tbl_write   = in_accept && (cmd == sfs_pkg::CMD_WRITE) &&
                         ({1'b0, i_entry_index} < sfs_pkg::FRAMES_LIMIT);

    assign frames    = (r_frame_count > sfs_pkg::FRAMES_LIMIT) ?
                       sfs_pkg::FRAMES_LIMIT : r_frame_count;
    assign timed_lim = (r_timed_entries > sfs_pkg::FRAMES_LIMIT) ?
                       sfs_pkg::FRAMES_LIMIT : r_timed_entries;
    assign cur_dur   = ({1'b0, r_frame} < timed_lim) ? r_dur_q : r_default_ticks;
    assign elapsed_inc = (r_elapsed < sfs_pkg::TIME_MAX) ?
                         r_elapsed + sfs_pkg::TIME_BITS'(1) : r_elapsed;
    assign due = r_playing & ~r_finished & ~r_hidden &
                 (CMP_W'(elapsed_inc) >= CMP_W'(cur_dur));
    assign step_frame = {1'b0, r_frame} + sfs_pkg::COUNT_W'(1);

    // configuration writes
    always_comb begin
        n_default_ticks = r_default_ticks;
        n_loop_enable   = r_loop_enable;
        n_frame_count   = r_frame_count;
        n_timed_entries = r_timed_entries;
        n_frame_width   = r_frame_width;
        n_start_x       = r_start_x;
        n_start_y       = r_start_y;
        if (cfg_write) begin
            case (sfs_pkg::t_cfg_reg'(i_cfg_index))
                sfs_pkg::CFG_DEFAULT_TICKS: begin
                    n_default_ticks = (i_cfg_data == '0) ? sfs_pkg::RESET_FRAME_TICKS
                                                         : i_cfg_data;
                end
                sfs_pkg::CFG_LOOP_ENABLE:   n_loop_enable   = i_cfg_data[0];
                sfs_pkg::CFG_FRAME_COUNT:   n_frame_count   = i_cfg_data[sfs_pkg::COUNT_W-1:0];
                sfs_pkg::CFG_TIMED_ENTRIES: n_timed_entries = i_cfg_data[sfs_pkg::COUNT_W-1:0];
                sfs_pkg::CFG_FRAME_WIDTH:   n_frame_width   = i_cfg_data[sfs_pkg::COORD_W-1:0];
                sfs_pkg::CFG_START_X:       n_start_x       = i_cfg_data[sfs_pkg::COORD_W-1:0];
                sfs_pkg::CFG_START_Y:       n_start_y       = i_cfg_data[sfs_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // command execution
    always_comb begin
        n_playing  = r_playing;
        n_finished = r_finished;
        n_hidden   = r_hidden;
        n_frame    = r_frame;
        n_elapsed  = r_elapsed;
        advanced   = 1'b0;
        rejected   = 1'b0;
        if (in_accept) begin
            case (cmd)
                sfs_pkg::CMD_TICK: begin
                    n_elapsed = elapsed_inc;
                    if (due) begin
                        n_elapsed = '0;
                        if (frames != '0) begin
                            if (step_frame >= frames) begin
                                if (r_loop_enable) begin
                                    n_frame  = '0;
                                    advanced = 1'b1;
                                end else begin
                                    // one-shot end: hold on the last frame
                                    n_frame    = sfs_pkg::FRAME_W'(frames - sfs_pkg::COUNT_W'(1));
                                    n_playing  = 1'b0;
                                    n_finished = 1'b1;
                                end
                            end else begin
                                n_frame  = step_frame[sfs_pkg::FRAME_W-1:0];
                                advanced = 1'b1;
                            end
                        end
                    end
                end
                sfs_pkg::CMD_PLAY: begin
                    if (frames == '0) begin
                        rejected = 1'b1;
                    end else begin
                        n_playing  = 1'b1;
                        n_finished = 1'b0;
                        n_elapsed  = '0;
                    end
                end
                sfs_pkg::CMD_PAUSE: n_playing = 1'b0;
                sfs_pkg::CMD_STOP: begin
                    n_playing  = 1'b0;
                    n_finished = 1'b1;
                    n_frame    = '0;
                end
                sfs_pkg::CMD_RESTART: begin
                    n_frame    = '0;
                    n_finished = 1'b0;
                    n_elapsed  = '0;
                end
                sfs_pkg::CMD_SHOW: n_hidden = 1'b0;
                sfs_pkg::CMD_HIDE: n_hidden = 1'b1;
                default: ;
            endcase
        end
        // assigning frames restarts the animation position
        if (cfg_write && (sfs_pkg::t_cfg_reg'(i_cfg_index) == sfs_pkg::CFG_FRAME_COUNT)) begin
            n_frame    = '0;
            n_finished = 1'b0;
        end
    end

    // result formation
    assign rect_prod = PROD_W'(n_frame) * PROD_W'(r_frame_width);
    assign rect_sum  = SUM_W'(rect_prod) + SUM_W'(r_start_x);

    always_comb begin
        n_out.frame_index = n_frame;
        n_out.rect_x      = (rect_sum > SUM_W'({sfs_pkg::RECT_W{1'b1}})) ?
                            {sfs_pkg::RECT_W{1'b1}} : sfs_pkg::RECT_W'(rect_sum);
        n_out.rect_y      = r_start_y;
        n_out.is_playing  = n_playing;
        n_out.is_finished = n_finished;
        n_out.is_visible  = ~n_hidden & (frames != '0);
        n_out.advanced    = advanced;
        n_out.rejected    = rejected;
        n_out_valid       = in_accept | (r_out_valid & i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_ticks <= sfs_pkg::RESET_FRAME_TICKS;
            r_loop_enable   <= 1'b0;
            r_frame_count   <= '0;
            r_timed_entries <= '0;
            r_frame_width   <= '0;
            r_start_x       <= '0;
            r_start_y       <= '0;
            r_playing       <= 1'b0;
            r_finished      <= 1'b0;
            r_hidden        <= 1'b0;
            r_frame         <= '0;
            r_elapsed       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_default_ticks <= n_default_ticks;
            r_loop_enable   <= n_loop_enable;
            r_frame_count   <= n_frame_count;
            r_timed_entries <= n_timed_entries;
            r_frame_width   <= n_frame_width;
            r_start_x       <= n_start_x;
            r_start_y       <= n_start_y;
            r_playing       <= n_playing;
            r_finished      <= n_finished;
            r_hidden        <= n_hidden;
            r_frame         <= n_frame;
            r_elapsed       <= n_elapsed;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    // table is read at the frame the next item will see
    always_ff @(posedge i_clk) begin
        if (tbl_write) begin
            r_dur_mem[i_entry_index] <= i_entry_ticks;
        end
        if (tbl_write && (i_entry_index == n_frame)) begin
            r_dur_q <= i_entry_ticks;
        end else begin
            r_dur_q <= r_dur_mem[n_frame];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_index = r_out.frame_index;
    assign o_rect_x      = r_out.rect_x;
    assign o_rect_y      = r_out.rect_y;
    assign o_is_playing  = r_out.is_playing;
    assign o_is_finished = r_out.is_finished;
    assign o_is_visible  = r_out.is_visible;
    assign o_advanced    = r_out.advanced;
    assign o_rejected    = r_out.rejected;

    `SFS_ASSERT_NOW(a_play_fin_excl, i_clk, i_rst_n, r_out_valid, !(r_out.is_playing && r_out.is_finished))
    `SFS_ASSERT_NOW(a_adv_while_play, i_clk, i_rst_n, r_out_valid && r_out.advanced, r_out.is_playing)
    `SFS_ASSERT_NEXT(a_accept_to_out, i_clk, i_rst_n, in_accept, r_out_valid)

endmodule
